@@ src/ipmac_pkg.sv @@
// ----------------------------------------------------------------------------
// ipmac_pkg
// Shared types and constants for the IPv4-to-MAC aging cache.
// ----------------------------------------------------------------------------
package ipmac_pkg;

    // Default table depth
    localparam int unsigned CACHE_ENTRIES_DEF = 128;

    // Field widths
    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int TIME_W = 32;
    localparam int LIFE_W = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Lifetime register reset value, in seconds
    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd300;

    // Request operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Register index (word address bit of paddr)
    localparam logic REG_LIFETIME = 1'b0;

    // One table entry as stored in memory
    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    // Compare results on the entry just read
    typedef struct packed {
        logic match;    // address equals key
        logic expired;  // age at or past lifetime
        logic older;    // stamp below running minimum
    } t_probe;

endpackage

@@ src/ip_to_mac_aging_cache.sv @@
// ----------------------------------------------------------------------------
// ip_to_mac_aging_cache
// IPv4-to-MAC cache with per-entry insert stamp and lifetime expiry.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. operation 0 looks
//   up i_ip_addr; operation 1 inserts i_ip_addr/i_mac_in stamped with
//   i_now_seconds. Every request returns one result on o_hit/o_mac_out,
//   marked by a one-cycle o_done pulse; the receiver cannot stall it.
//   busy drops in the cycle o_done is shown, so the next request may be
//   taken in that same cycle.
// Request handling (from accept to o_done):
//   insert with room / lookup of an empty table: answered from idle, no scan.
//   lookup: entries are checked in order, stopping at the first live match;
//     each expired match is removed by a fetch of the last entry, which is
//     then checked in the freed slot.
//   insert into a full table: a scan of all entries for the stamp minimum.
//   The scan is set by the single read port of the entry memory: one entry
//   per cycle.
// Reset: lifetime returns to 300 s and the table is empty. Entry memory is
//   not cleared; no clearing pass, requests are taken right away.
// The user must write the lifetime register over the APB port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module ip_to_mac_aging_cache #(
    parameter int unsigned CACHE_ENTRIES = ipmac_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_operation,
    input  logic [ipmac_pkg::IP_W-1:0]     i_ip_addr,
    input  logic [ipmac_pkg::MAC_W-1:0]    i_mac_in,
    input  logic [ipmac_pkg::TIME_W-1:0]   i_now_seconds,
    // result channel
    output logic                           o_done,
    output logic                           o_hit,
    output logic [ipmac_pkg::MAC_W-1:0]    o_mac_out,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ipmac_pkg::ADDR_W-1:0]   paddr,
    input  logic [ipmac_pkg::DATA_W-1:0]   pwdata,
    output logic [ipmac_pkg::DATA_W-1:0]   prdata,
    output logic                           pready
);
    import ipmac_pkg::*;

    localparam int IDX_W = $clog2(CACHE_ENTRIES);
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CACHE_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_MOVE  = 4'b0100,
        S_EVICT = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_victim, n_victim;
    logic [TIME_W-1:0]   r_min, n_min;
    logic                r_moved, n_moved;
    logic                r_done, n_done;
    logic                r_hit, n_hit;
    logic [MAC_W-1:0]    r_mac_out, n_mac_out;
    logic [LIFE_W-1:0]   r_lifetime;
    logic [IP_W-1:0]     r_ip;
    logic [MAC_W-1:0]    r_mac;
    logic [TIME_W-1:0]   r_now;

    logic                accept;
    logic                cfg_wr;
    logic [CNT_W-1:0]    idx_c, idx_next_c, last_c;
    logic                take;
    logic [IDX_W-1:0]    cur_victim;
    logic                we;
    logic [IDX_W-1:0]    waddr, raddr;
    t_entry              wdata, rd_data;
    t_probe              probe;

    // Entry memory and compares
    ipmac_store #(
        .ENTRIES     (CACHE_ENTRIES)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (we),
        .i_wr_addr   (waddr),
        .i_wr_data   (wdata),
        .i_rd_addr   (raddr),
        .i_key_ip    (r_ip),
        .i_now       (r_now),
        .i_lifetime  (r_lifetime),
        .i_min_stamp (r_min),
        .o_rd_data   (rd_data),
        .o_probe     (probe)
    );

    assign accept     = start && (r_state == S_IDLE);
    assign idx_c      = CNT_W'(r_idx);
    assign idx_next_c = CNT_W'(r_idx) + CNT_W'(1);
    assign last_c     = r_count - CNT_W'(1);

    // Victim tracking for the full-table insert
    assign take       = (r_idx == '0) || probe.older;
    assign cur_victim = take ? r_idx : r_victim;

    // Scan control; the read of the next entry is issued while checking this one
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_victim  = r_victim;
        n_min     = r_min;
        n_moved   = 1'b0;
        n_done    = 1'b0;
        n_hit     = 1'b0;
        n_mac_out = '0;
        we        = 1'b0;
        waddr     = r_idx;
        wdata     = rd_data;
        raddr     = idx_next_c[IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                raddr = '0;
                if (accept) begin
                    n_idx = '0;
                    if (i_operation == OP_INSERT) begin
                        if (r_count < CNT_FULL) begin
                            we      = 1'b1;
                            waddr   = r_count[IDX_W-1:0];
                            wdata   = '{ip: i_ip_addr, mac: i_mac_in, stamp: i_now_seconds};
                            n_count = r_count + CNT_W'(1);
                            n_done  = 1'b1;
                        end else begin
                            n_state = S_EVICT;
                        end
                    end else if (r_count == '0) begin
                        n_done = 1'b1;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                // finish moving the last entry into the freed slot
                if (r_moved) begin
                    we = 1'b1;
                end
                if (probe.match && !probe.expired) begin
                    n_done    = 1'b1;
                    n_hit     = 1'b1;
                    n_mac_out = rd_data.mac;
                    n_state   = S_IDLE;
                end else if (probe.match) begin
                    n_count = last_c;
                    if (idx_c == last_c) begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_MOVE;
                    end
                end else if (idx_next_c < r_count) begin
                    n_idx = idx_next_c[IDX_W-1:0];
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MOVE: begin
                // fetch the last entry; it is checked in this slot next
                raddr   = r_count[IDX_W-1:0];
                n_moved = 1'b1;
                n_state = S_LOOK;
            end
            S_EVICT: begin
                n_victim = cur_victim;
                n_min    = take ? rd_data.stamp : r_min;
                if (idx_next_c == r_count) begin
                    we      = 1'b1;
                    waddr   = cur_victim;
                    wdata   = '{ip: r_ip, mac: r_mac, stamp: r_now};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx = idx_next_c[IDX_W-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_moved <= 1'b0;
            r_done  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_moved <= n_moved;
            r_done  <= n_done;
            r_hit   <= n_hit;
        end
    end

    // Scan payload and result data
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_victim  <= n_victim;
        r_min     <= n_min;
        r_mac_out <= n_mac_out;
        if (accept) begin
            r_ip  <= i_ip_addr;
            r_mac <= i_mac_in;
            r_now <= i_now_seconds;
        end
    end

    // Lifetime register
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LIFETIME);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= LIFETIME_RESET;
        end else if (cfg_wr) begin
            r_lifetime <= pwdata[LIFE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LIFETIME) ?
                    {{(DATA_W-LIFE_W){1'b0}}, r_lifetime} : '0;

    // Outputs
    assign busy      = (r_state != S_IDLE);
    assign o_done    = r_done;
    assign o_hit     = r_hit;
    assign o_mac_out = r_mac_out;

endmodule

@@ src/ipmac_store.sv @@
// ----------------------------------------------------------------------------
// ipmac_store
// Entry memory (one write port, one registered read port) plus the key,
// age and stamp compares on the entry read out.
// ----------------------------------------------------------------------------
module ipmac_store #(
    parameter int unsigned ENTRIES = ipmac_pkg::CACHE_ENTRIES_DEF,
    localparam int IDX_W = $clog2(ENTRIES)
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [IDX_W-1:0]               i_wr_addr,
    input  ipmac_pkg::t_entry              i_wr_data,
    input  logic [IDX_W-1:0]               i_rd_addr,
    input  logic [ipmac_pkg::IP_W-1:0]     i_key_ip,
    input  logic [ipmac_pkg::TIME_W-1:0]   i_now,
    input  logic [ipmac_pkg::LIFE_W-1:0]   i_lifetime,
    input  logic [ipmac_pkg::TIME_W-1:0]   i_min_stamp,
    output ipmac_pkg::t_entry              o_rd_data,
    output ipmac_pkg::t_probe              o_probe
);
    import ipmac_pkg::*;

    t_entry              mem [ENTRIES];
    t_entry              r_rd_data;
    logic [TIME_W-1:0]   age;

    // Memory write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Memory read port, registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    // Signed age: a stamp in the future is always live
    assign age = i_now - r_rd_data.stamp;

    always_comb begin
        o_probe.match   = (r_rd_data.ip == i_key_ip);
        o_probe.expired = !age[TIME_W-1] &&
                          (age >= {{(TIME_W-LIFE_W){1'b0}}, i_lifetime});
        o_probe.older   = (r_rd_data.stamp < i_min_stamp);
    end

    assign o_rd_data = r_rd_data;

endmodule
